### rtl/core/lru_recency_list_macros.svh
// Assertion macros for the recency list block.
// Included by the top level; no other dependencies.
`ifndef LRU_RECENCY_LIST_MACROS_SVH
`define LRU_RECENCY_LIST_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LRL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("recency list: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define LRL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("recency list: next-cycle check failed");

`endif

### rtl/core/lrl_pkg.sv
// Shared constants, types and helpers for the recency list block.
// No dependencies; imported by every module of the block.
`default_nettype none

package lrl_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int MAX_READ   = 16;
    localparam int TOP_CAP    = (LIST_DEPTH < MAX_READ) ? LIST_DEPTH : MAX_READ;

    localparam int KEY_W     = 32;
    localparam int POS_W     = 4;
    localparam int CAP_W     = 5;
    localparam int CAP_RESET = 16;

    localparam int CNT_W     = $clog2(TOP_CAP + 1);
    localparam int RD_W      = (TOP_CAP > 1) ? $clog2(TOP_CAP) : 1;
    localparam int SLOT_W    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int M_TDATA_W = ((KEY_W + POS_W + 7) / 8) * 8;

    typedef enum logic
    {
        FUNC_INSERT = 1'b0,
        FUNC_READ   = 1'b1
    } lrl_func_t;

    typedef enum logic
    {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } lrl_state_t;

    typedef struct packed
    {
        logic insert;
        logic rd_load;
    } lrl_cmd_t;

    typedef struct packed
    {
        logic rd_last;
    } lrl_stat_t;

    // Clamp the capacity register to 1 .. TOP_CAP
    function automatic logic [CNT_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
        logic [CNT_W-1:0] res;
        if (cap == '0)
        begin
            res = CNT_W'(1);
        end
        else if (int'(cap) > TOP_CAP)
        begin
            res = CNT_W'(TOP_CAP);
        end
        else
        begin
            res = CNT_W'(cap);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/core/lrl_ctrl.sv
// Sequencer for the recency list: accepts items, steps a read-out, owns tvalid.
// Depends on lrl_pkg.
`default_nettype none

module lrl_ctrl
    import lrl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire lrl_func_t in_func,
    output logic           in_ready,
    input  wire logic      out_ready,
    output logic           out_valid,
    input  wire lrl_stat_t stat,
    output lrl_cmd_t       cmd
);

    lrl_state_t state_reg;
    lrl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        accept      = 1'b0;
        cmd.insert  = 1'b0;
        cmd.rd_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                accept   = in_valid;
                if (accept)
                begin
                    if (in_func == FUNC_READ)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.insert = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                // advance when the output register is free or being emptied
                cmd.rd_load = !out_valid_reg || out_ready;
                if (cmd.rd_load && stat.rd_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.rd_load ? 1'b1 : (out_valid_reg && !out_ready);
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/core/lrl_datapath.sv
// Key cell row with parallel compare and shift, count, capacity and output register.
// Depends on lrl_pkg.
`default_nettype none

module lrl_datapath
    import lrl_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_wdata,
    input  wire logic [KEY_W-1:0] in_key,
    input  wire lrl_cmd_t         cmd,
    output lrl_stat_t             stat,
    output logic [KEY_W-1:0]      out_key,
    output logic [POS_W-1:0]      out_pos,
    output logic                  out_entry_valid,
    output logic                  out_last
);

    logic [KEY_W-1:0]      keys_reg [LIST_DEPTH];
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [CAP_W-1:0]      cap_reg;
    logic [RD_W-1:0]       rd_idx_reg;
    logic [RD_W-1:0]       rd_idx_next;
    logic [KEY_W-1:0]      out_key_reg;
    logic [POS_W-1:0]      out_pos_reg;
    logic                  out_entry_valid_reg;
    logic                  out_last_reg;

    logic [CNT_W-1:0]      eff;
    logic [CNT_W-1:0]      eff_new;
    logic [CNT_W-1:0]      lim;
    logic [LIST_DEPTH-1:0] match;
    logic [LIST_DEPTH-1:0] shift_en;
    logic                  any_match;
    logic                  empty;

    // Compare every valid cell against the key; shift cells from 1 up to the first hit or the limit
    always_comb
    begin
        eff     = eff_capacity(cap_reg);
        eff_new = eff_capacity(cfg_wdata);
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            match[i] = (i < int'(cnt_reg)) && (keys_reg[i] == in_key);
        end
        any_match = |match;
        lim = (cnt_reg < eff) ? cnt_reg : (eff - CNT_W'(1));
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            shift_en[i] = (i > 0) && (i <= int'(lim))
                && ((match & ((LIST_DEPTH'(1) << i) - LIST_DEPTH'(1))) == '0);
        end

        cnt_next = cnt_reg;
        if (cfg_we)
        begin
            // drop the oldest entries when capacity shrinks
            cnt_next = (cnt_reg < eff_new) ? cnt_reg : eff_new;
        end
        else if (cmd.insert && !any_match && (cnt_reg < eff))
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        empty        = (cnt_reg == '0);
        stat.rd_last = (CNT_W'(rd_idx_reg) + CNT_W'(1)) >= cnt_reg;
        rd_idx_next  = rd_idx_reg;
        if (cmd.rd_load)
        begin
            rd_idx_next = stat.rd_last ? '0 : (rd_idx_reg + RD_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            cap_reg    <= CAP_W'(CAP_RESET);
            rd_idx_reg <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            rd_idx_reg <= rd_idx_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            keys_reg[0] <= in_key;
            for (int i = 1; i < LIST_DEPTH; i++)
            begin
                if (shift_en[i])
                begin
                    keys_reg[i] <= keys_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_load)
        begin
            out_key_reg         <= empty ? '0 : keys_reg[SLOT_W'(rd_idx_reg)];
            out_pos_reg         <= POS_W'(rd_idx_reg);
            out_entry_valid_reg <= !empty;
            out_last_reg        <= stat.rd_last;
        end
    end

    assign out_key         = out_key_reg;
    assign out_pos         = out_pos_reg;
    assign out_entry_valid = out_entry_valid_reg;
    assign out_last        = out_last_reg;

endmodule

`default_nettype wire

### rtl/core/lru_recency_list.sv
// Most-recently-used key list: insert/touch an item moves its key to the head
// (all cells compare and shift in parallel); a read item streams the list out
// newest first. Inserts can be taken back to back. A read yields max(count,1)
// results, paced by the single output register that the sequencer reloads; the
// next item is taken the cycle after the last result is loaded. Capacity is
// clamped to 1..16 and shrinking it drops the oldest entries. Depends on lrl_pkg,
// lrl_ctrl, lrl_datapath.
`default_nettype none

`include "lru_recency_list_macros.svh"

module lru_recency_list
    import lrl_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CAP_W-1:0]     cfg_wdata,      // capacity_in_use
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [KEY_W-1:0]     s_axis_tdata,   // [31:0] key
    input  wire logic                 s_axis_tuser,   // [0] func
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,   // [31:0] entry_key, [35:32] entry_position
    output logic                      m_axis_tuser,   // [0] entry_valid
    output logic                      m_axis_tlast    // last_of_run
);

    lrl_cmd_t         cmd;
    lrl_stat_t        stat;
    logic [KEY_W-1:0] out_key;
    logic [POS_W-1:0] out_pos;

    lrl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_func   (lrl_func_t'(s_axis_tuser)),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .stat      (stat),
        .cmd       (cmd)
    );

    lrl_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_key          (s_axis_tdata),
        .cmd             (cmd),
        .stat            (stat),
        .out_key         (out_key),
        .out_pos         (out_pos),
        .out_entry_valid (m_axis_tuser),
        .out_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {{(M_TDATA_W - KEY_W - POS_W){1'b0}}, out_pos, out_key};

    // Read-out loads happen only while no new item can be taken
    `LRL_ASSERT_IMP(a_load_blocks_input, clk, rst_n, cmd.rd_load, !s_axis_tready)
    // Loading the final result hands control back to the input side
    `LRL_ASSERT_NXT(a_last_frees_input, clk, rst_n, cmd.rd_load && stat.rd_last, s_axis_tready)
    // An empty-list marker is always the only result of its read-out
    `LRL_ASSERT_IMP(a_empty_is_last, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)
    // An insert never coincides with a read-out step
    `LRL_ASSERT_IMP(a_insert_excl_load, clk, rst_n, cmd.insert, !cmd.rd_load)

endmodule

`default_nettype wire
